// ===== src/mtep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the MIDI track event parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_DELTA     = 4'd0;
  localparam logic [PhaseW-1:0] PH_STATUS    = 4'd1;
  localparam logic [PhaseW-1:0] PH_META_TYPE = 4'd2;
  localparam logic [PhaseW-1:0] PH_LEN       = 4'd3;
  localparam logic [PhaseW-1:0] PH_SKIP      = 4'd4;
  localparam logic [PhaseW-1:0] PH_DATA1     = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA2     = 4'd6;

  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_TEMPO = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] abs_tick;
    logic        event_kind;
    logic [23:0] event_word;
  } mtep_result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              halted;
  } mtep_status_t;

endpackage

// ===== src/mtep_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and the single-pass step logic for one track byte.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output mtep_result_t result,
  output mtep_status_t status
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [7:0]        running_status, running_status_next;
  logic [31:0]       tick_sum, tick_sum_next;
  logic [31:0]       vlq_accum, vlq_accum_next;
  logic [31:0]       bytes_remaining, bytes_remaining_next;
  logic [7:0]        meta_kind, meta_kind_next;
  logic [23:0]       payload_capture, payload_capture_next;
  logic              halted, halted_next;

  logic [31:0] vlq_shift;
  logic [31:0] rem_dec;
  logic        rs_sysex;
  logic        rs_one_data;

  assign vlq_shift   = {vlq_accum[24:0], data_byte[6:0]};
  assign rem_dec     = bytes_remaining - 32'd1;
  assign rs_sysex    = (running_status == ST_SYSEX) || (running_status == ST_SYSEX_CONT);
  assign rs_one_data = (running_status[7:4] == HI_PROGRAM) ||
                       (running_status[7:4] == HI_PRESSURE);

  always_comb begin
    phase_next           = phase;
    running_status_next  = running_status;
    tick_sum_next        = tick_sum;
    vlq_accum_next       = vlq_accum;
    bytes_remaining_next = bytes_remaining;
    meta_kind_next       = meta_kind;
    payload_capture_next = payload_capture;
    halted_next          = halted;
    result.valid         = 1'b0;
    result.abs_tick      = tick_sum;
    result.event_kind    = KIND_SHORT;
    result.event_word    = {8'd0, data_byte, running_status};

    if (!halted) begin
      unique case (phase)
        PH_DELTA: begin
          vlq_accum_next = vlq_shift;
          if (!data_byte[7]) begin
            tick_sum_next  = tick_sum + vlq_shift;
            vlq_accum_next = 32'd0;
            phase_next     = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (data_byte[7]) begin
            running_status_next = data_byte;
            if (data_byte == ST_META) begin
              phase_next = PH_META_TYPE;
            end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_CONT) begin
              phase_next = PH_LEN;
            end else begin
              phase_next = PH_DATA1;
            end
          end else if (running_status == 8'd0) begin
            halted_next = 1'b1;
          end else if (running_status == ST_META) begin
            meta_kind_next = data_byte;
            phase_next     = PH_LEN;
          end else if (rs_sysex) begin
            vlq_accum_next = vlq_shift;
            if (!data_byte[7]) begin
              if (vlq_shift == 32'd0) begin
                phase_next = PH_DELTA;
              end else begin
                bytes_remaining_next = vlq_shift;
                payload_capture_next = 24'd0;
                phase_next           = PH_SKIP;
              end
            end
          end else begin
            payload_capture_next = {16'd0, data_byte};
            if (rs_one_data) begin
              result.valid = 1'b1;
              phase_next   = PH_DELTA;
            end else begin
              phase_next = PH_DATA2;
            end
          end
        end
        PH_META_TYPE: begin
          meta_kind_next = data_byte;
          phase_next     = PH_LEN;
        end
        PH_LEN: begin
          vlq_accum_next = vlq_shift;
          if (!data_byte[7]) begin
            if (vlq_shift == 32'd0) begin
              phase_next = PH_DELTA;
            end else begin
              bytes_remaining_next = vlq_shift;
              payload_capture_next = 24'd0;
              phase_next           = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          payload_capture_next = {payload_capture[15:0], data_byte};
          bytes_remaining_next = rem_dec;
          result.event_kind    = KIND_TEMPO;
          result.event_word    = {payload_capture[15:0], data_byte};
          if (rem_dec == 32'd0) begin
            result.valid   = (running_status == ST_META) && (meta_kind == META_TEMPO) &&
                             (vlq_accum == 32'd3);
            vlq_accum_next = 32'd0;
            phase_next     = PH_DELTA;
          end
        end
        PH_DATA1: begin
          payload_capture_next = {16'd0, data_byte};
          if (rs_one_data) begin
            result.valid = 1'b1;
            phase_next   = PH_DELTA;
          end else begin
            phase_next = PH_DATA2;
          end
        end
        PH_DATA2: begin
          result.valid      = 1'b1;
          result.event_word = {data_byte, payload_capture[7:0], running_status};
          phase_next        = PH_DELTA;
        end
        default: begin
          halted_next = 1'b1;
        end
      endcase
    end

    if (last_byte) begin
      phase_next           = PH_DELTA;
      running_status_next  = 8'd0;
      tick_sum_next        = 32'd0;
      vlq_accum_next       = 32'd0;
      bytes_remaining_next = 32'd0;
      meta_kind_next       = 8'd0;
      payload_capture_next = 24'd0;
      halted_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DELTA;
      running_status  <= 8'd0;
      tick_sum        <= 32'd0;
      vlq_accum       <= 32'd0;
      bytes_remaining <= 32'd0;
      meta_kind       <= 8'd0;
      payload_capture <= 24'd0;
      halted          <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      running_status  <= running_status_next;
      tick_sum        <= tick_sum_next;
      vlq_accum       <= vlq_accum_next;
      bytes_remaining <= bytes_remaining_next;
      meta_kind       <= meta_kind_next;
      payload_capture <= payload_capture_next;
      halted          <= halted_next;
    end
  end

  assign status.phase  = phase;
  assign status.halted = halted;

endmodule

// ===== src/mtep_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module mtep_out_reg import mtep_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  mtep_result_t result,
  output logic         tvalid,
  input  logic         tready,
  output logic [55:0]  tdata,  // abs_tick[31:0], event_word[55:32]
  output logic [0:0]   tuser   // event_kind
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= {result.event_word, result.abs_tick};
      tuser <= result.event_kind;
    end
  end

endmodule

// ===== src/midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses a MIDI track body byte by byte into timed short and tempo events.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata                         tuser        tlast
//  s_axis    in         data_byte[7:0]                -            last_byte
//  m_axis    out        abs_tick[31:0], word[55:32]   event_kind   -
//
// One byte a cycle is sustained while the result register is not stalled.
// Each byte is latched in an input register, then one pass of the step logic
// updates the parser state and loads the result register. rst clears the
// parser to its start-of-track state; last_byte does the same after its
// byte. A stalled result register holds the step, and the input register
// then holds its byte.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // abs_tick[31:0], event_word[55:32]
  output logic [0:0]  m_tuser    // event_kind
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         out_free;
  logic         fire;
  logic         load;
  mtep_result_t res;
  mtep_status_t st;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign load     = fire && res.valid;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  mtep_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (res),
    .status    (st)
  );

  mtep_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .result (res),
    .tvalid (m_tvalid),
    .tready (m_tready),
    .tdata  (m_tdata),
    .tuser  (m_tuser)
  );

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    fire && in_last |=> st.phase == PH_DELTA && !st.halted)
    else $error("parser not back at delta phase after last byte");

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    st.halted |-> !res.valid)
    else $error("event produced while halted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !load)
    else $error("result register overwritten while stalled");

  a_tempo_from_skip: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.event_kind == KIND_TEMPO |-> st.phase == PH_SKIP)
    else $error("tempo event outside payload skip");

endmodule

// ===== tb/midi_track_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_checker
// Watches both streams of the MIDI track event parser. Every byte word taken
// on the input side is run through an independent model of the track parser,
// which queues the events it produces; every result word is then compared,
// field by field, with the oldest queued event.
// ----------------------------------------------------------------------------
module midi_track_event_checker import mtep_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [55:0]       m_tdata,
  input  logic [0:0]        m_tuser,
  output int unsigned       mismatches,
  output int unsigned       expected_left
);

  localparam logic [7:0] NO_STATUS    = 8'h00;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [PhaseW-1:0] phase;
  logic [7:0]        status_byte;
  logic [7:0]        meta_type;
  logic [31:0]       tick;
  logic [31:0]       vlq;
  logic [31:0]       remaining;
  logic [23:0]       capture;
  logic              halted;

  mtep_result_t pending_events[$];
  mtep_result_t got;
  mtep_result_t want;

  task automatic clear_parser();
    phase       = PH_DELTA;
    status_byte = NO_STATUS;
    meta_type   = '0;
    tick        = '0;
    vlq         = '0;
    remaining   = '0;
    capture     = '0;
    halted      = 1'b0;
  endtask

  task automatic queue_event(input logic kind, input logic [23:0] word);
    mtep_result_t ev;
    ev.valid      = 1'b1;
    ev.abs_tick   = tick;
    ev.event_kind = kind;
    ev.event_word = word;
    pending_events.insert(pending_events.size(), ev);
  endtask

  // A length of zero ends the event at once; otherwise the payload is skipped.
  task automatic take_length(input logic [7:0] b);
    vlq = {vlq[24:0], b[6:0]};
    if (!b[7]) begin
      if (vlq == 0) begin
        phase = PH_DELTA;
      end else begin
        remaining = vlq;
        capture   = '0;
        phase     = PH_SKIP;
      end
    end
  endtask

  task automatic take_first_data(input logic [7:0] b);
    capture = {16'h0000, b};
    if (status_byte[7:4] == HI_PROGRAM || status_byte[7:4] == HI_PRESSURE) begin
      phase = PH_DELTA;
      queue_event(KIND_SHORT, {8'h00, b, status_byte});
    end else begin
      phase = PH_DATA2;
    end
  endtask

  task automatic parse_track_byte(input logic [7:0] b, input logic last);
    if (!halted) begin
      case (phase)
        PH_DELTA: begin
          vlq = {vlq[24:0], b[6:0]};
          if (!b[7]) begin
            tick  = tick + vlq;
            vlq   = '0;
            phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            status_byte = b;
            if (b == ST_META) begin
              phase = PH_META_TYPE;
            end else if (b == ST_SYSEX || b == ST_SYSEX_CONT) begin
              phase = PH_LEN;
            end else begin
              phase = PH_DATA1;
            end
          end else if (status_byte == NO_STATUS) begin
            halted = 1'b1;
          end else if (status_byte == ST_META) begin
            meta_type = b;
            phase     = PH_LEN;
          end else if (status_byte == ST_SYSEX || status_byte == ST_SYSEX_CONT) begin
            take_length(b);
          end else begin
            take_first_data(b);
          end
        end
        PH_META_TYPE: begin
          meta_type = b;
          phase     = PH_LEN;
        end
        PH_LEN: take_length(b);
        PH_SKIP: begin
          capture   = {capture[15:0], b};
          remaining = remaining - 1;
          if (remaining == 0) begin
            if (status_byte == ST_META && meta_type == META_TEMPO && vlq == 3) begin
              queue_event(KIND_TEMPO, capture);
            end
            vlq   = '0;
            phase = PH_DELTA;
          end
        end
        PH_DATA1: take_first_data(b);
        PH_DATA2: begin
          phase = PH_DELTA;
          queue_event(KIND_SHORT, {b, capture[7:0], status_byte});
        end
        default: halted = 1'b1;
      endcase
    end
    if (last) begin
      clear_parser();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      pending_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.valid      = 1'b1;
        got.abs_tick   = m_tdata[31:0];
        got.event_word = m_tdata[55:32];
        got.event_kind = m_tuser[0];
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected event: tick %h kind %0d word %h",
                     got.abs_tick, got.event_kind, got.event_word);
          end
        end else begin
          want = pending_events.pop_front();
          if (got.abs_tick !== want.abs_tick || got.event_kind !== want.event_kind ||
              got.event_word !== want.event_word) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("event mismatch: expected tick %h kind %0d word %h,",
                       want.abs_tick, want.event_kind, want.event_word,
                       " got tick %h kind %0d word %h",
                       got.abs_tick, got.event_kind, got.event_word);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        parse_track_byte(s_tdata, s_tlast);
      end
    end
    expected_left = pending_events.size();
  end

endmodule

// ===== tb/tb_midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Feeds the MIDI track event parser with track bodies: a short directed set
// covering every event type and the awkward corners, then random tracks built
// mostly from well-formed events, with truncated and noisy tracks mixed in.
// Both sides stall at random; the result side also holds off for a long
// stretch once. The checker beside the block reports the mismatch count.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
  import mtep_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 600;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned mismatches;
  int unsigned expected_left;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  int unsigned tracks      = 0;
  logic [8:0]  track_words[$];
  logic [7:0]  gen_status  = 8'h00;
  bit          rx_hold_req = 1'b0;
  bit          rx_steady   = 1'b0;

  always #10 clk = ~clk;

  midi_track_event_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  midi_track_event_checker event_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_midi_track_event_parser NOT OK");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    track_words.insert(track_words.size(), {1'b0, b});
  endtask

  // Data bytes are mostly 7-bit, but the block takes raw bytes as well.
  task automatic put_data();
    put(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127)));
  endtask

  task automatic mark_last();
    logic [8:0] w;
    w = track_words.pop_back();
    w[8] = 1'b1;
    track_words.insert(track_words.size(), w);
  endtask

  task automatic put_delta();
    int unsigned pick;
    int unsigned groups;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      put(8'h00);
    end else begin
      groups = (pick < 75) ? 1 : (pick < 94) ? $urandom_range(2, 3) : $urandom_range(4, 7);
      repeat (groups - 1) put(8'h80 | 8'($urandom_range(0, 127)));
      put(8'($urandom_range(0, 127)));
    end
  endtask

  function automatic int unsigned random_length();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(128, 132) : $urandom_range(0, 6);
  endfunction

  task automatic put_payload(input int unsigned len);
    if (len > 127) begin
      put(8'h80 | 8'(len >> 7));
    end
    put(8'(len & 127));
    repeat (len) put(8'($urandom_range(0, 255)));
  endtask

  task automatic put_event();
    int unsigned pick;
    logic [7:0]  st;
    pick = $urandom_range(0, 99);
    put_delta();
    if (pick < 45) begin
      if (gen_status >= 8'h80 && gen_status < ST_SYSEX && $urandom_range(0, 1) == 1) begin
        st = gen_status;
      end else begin
        st = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'hF1, 8'hFE))
                                         : 8'($urandom_range(8'h80, 8'hEF));
        if (st == ST_SYSEX_CONT) begin
          st = 8'hF8;
        end
        put(st);
      end
      put_data();
      if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE) begin
        put_data();
      end
      gen_status = st;
    end else if (pick < 80) begin
      if (gen_status == ST_META && $urandom_range(0, 2) == 0) begin
        put((pick < 65) ? META_TEMPO : 8'($urandom_range(0, 127)));
      end else begin
        put(ST_META);
        put((pick < 65) ? META_TEMPO : 8'($urandom_range(0, 255)));
      end
      put_payload((pick < 65 && $urandom_range(0, 4) != 0) ? 3 : random_length());
      gen_status = ST_META;
    end else if (pick < 95) begin
      if (!((gen_status == ST_SYSEX || gen_status == ST_SYSEX_CONT) &&
            $urandom_range(0, 1) == 1)) begin
        gen_status = ($urandom_range(0, 1) == 1) ? ST_SYSEX : ST_SYSEX_CONT;
        put(gen_status);
      end
      put_payload(random_length());
    end else begin
      put(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic build_track();
    int unsigned pick;
    int unsigned cut;
    track_words.delete();
    gen_status = 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(3, 20)) put(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) put_event();
      if (pick < 25) begin
        cut = $urandom_range(1, track_words.size());
        while (track_words.size() > cut) void'(track_words.pop_back());
      end
    end
    mark_last();
  endtask

  task automatic play_track(input bit steady);
    logic [8:0]  w;
    int unsigned gap;
    while (track_words.size() != 0) begin
      w = track_words.pop_front();
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= w[7:0];
      s_tlast  <= w[8];
      do @(posedge clk); while (!s_tready);
      words_sent++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A data byte before any status halts the track until its last byte.
    put(8'h00); put(8'h40); put(8'h90);
    mark_last();
    play_track(1'b0);

    put(8'h00); put(8'h90); put(8'h00); put(8'hFF);
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
    put(8'hC5); put(8'h80);
    put(8'h00); put(ST_META); put(META_TEMPO); put(8'h03);
    put(8'h07); put(8'hA1); put(8'h20);
    put(8'h00); put(8'h00); put(8'h00);
    put(8'h00); put(ST_SYSEX); put(8'h01); put(ST_SYSEX_CONT);
    put(8'h00); put(8'h01); put(8'h7F);
    put(8'h00); put(8'hD0);
    mark_last();
    play_track(1'b0);
    drain();

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (tracks == 5) begin
        track_words.delete();
        repeat (25) begin
          put(8'h00);
          put(8'h90 | 8'($urandom_range(0, 15)));
          put(8'($urandom_range(0, 127)));
          put(8'($urandom_range(0, 127)));
        end
        mark_last();
        rx_hold_req = 1'b1;
        play_track(1'b1);
      end else begin
        build_track();
        play_track($urandom_range(0, 3) == 0);
      end
      tracks++;
      if (tracks == 20) begin
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_midi_track_event_parser OK");
    end else begin
      $display("tb_midi_track_event_parser NOT OK");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          hold_done;
    taken = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall = RX_HOLD_CYCLES;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
      if (taken % 16 == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
      end
    end
  end

endmodule
